// ===== design/fcpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fcpa_pkg
// Shared constants, request and status codes, and the control/status
// structures that pass between the pool allocator's controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fcpa_pkg;

    localparam int MAX_CHUNKS = 1024;
    localparam int ADDR_W     = 32;
    localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int CHUNK_W    = 21;
    localparam int ACHUNK_W   = CHUNK_W + 1;
    localparam int ALIGN_W    = 3;
    localparam int STAT_W     = 3;
    localparam int REQ_W      = 2;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [STAT_W-1:0] ST_NULL  = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd4;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_POOL  = 2'd1;
    localparam logic [1:0] REG_CHUNK = 2'd2;
    localparam logic [1:0] REG_ALIGN = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]  base_address;
        logic [31:0]        pool_bytes;
        logic [CHUNK_W-1:0] chunk_bytes;
        logic [ALIGN_W-1:0] align_log2;
    } t_cfg;

    typedef struct packed {
        logic              pop;
        logic              push;
        logic              set_code;
        logic [STAT_W-1:0] code;
        logic              clear_init;
        logic              fill_step;
        logic              fill_end;
        logic              load_out;
    } t_cmd;

    typedef struct packed {
        logic              alloc_ok;
        logic [STAT_W-1:0] free_code;
        logic              fill_more;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/fcpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcpa_ctrl
// Request sequencer: decodes each transaction, drives the datapath through
// pop, push and fill steps, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpa_ctrl
    import fcpa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [REQ_W-1:0] i_req_type,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire t_stat            i_stat,
    output t_cmd                  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.code  = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RESP;
                    case (i_req_type)
                        REQ_ALLOC: begin
                            if (i_stat.alloc_ok) begin
                                o_cmd.pop = 1'b1;
                            end else begin
                                o_cmd.set_code = 1'b1;
                                o_cmd.code     = ST_EMPTY;
                            end
                        end
                        REQ_FREE: begin
                            if (i_stat.free_code == ST_OK) begin
                                o_cmd.push = 1'b1;
                            end else begin
                                o_cmd.set_code = 1'b1;
                                o_cmd.code     = i_stat.free_code;
                            end
                        end
                        REQ_CLEAR: begin
                            o_cmd.clear_init = 1'b1;
                            n_state          = S_FILL;
                        end
                        default: begin
                            o_cmd.set_code = 1'b1;
                        end
                    endcase
                end
            end
            S_FILL: begin
                if (i_stat.fill_more) begin
                    o_cmd.fill_step = 1'b1;
                end else begin
                    o_cmd.fill_end = 1'b1;
                    n_state        = S_RESP;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== design/fcpa_dpath.sv =====
// ----------------------------------------------------------------------------
// fcpa_dpath
// Free stack memory, pool counters, clear geometry and fill walker, range
// checks and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpa_dpath
    import fcpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic [ADDR_W-1:0] i_release_address,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    output logic [ADDR_W-1:0]      o_chunk_address,
    output logic [STAT_W-1:0]      o_status,
    output logic [31:0]            o_used_bytes,
    output logic [CNT_W-1:0]       o_live_allocations
);

    logic [ADDR_W-1:0]   r_stack [MAX_CHUNKS];
    logic [ADDR_W-1:0]   r_rd_data;

    logic [CNT_W-1:0]    r_free_count;
    logic [CNT_W-1:0]    r_chunk_total;
    logic [ACHUNK_W-1:0] r_aligned_chunk;
    logic [ADDR_W-1:0]   r_last_addr;
    logic [31:0]         r_used;
    logic [CNT_W-1:0]    r_alloc_count;
    logic [31:0]         r_remain;
    logic [ADDR_W-1:0]   r_fill_addr;
    logic                r_popped;
    logic [STAT_W-1:0]   r_code;

    logic [ADDR_W-1:0]   r_out_addr;
    logic [STAT_W-1:0]   r_out_status;
    logic [31:0]         r_out_used;
    logic [CNT_W-1:0]    r_out_alloc;

    logic [7:0]          w_mask;
    logic [7:0]          w_offset;
    logic [31:0]         w_usable;
    logic [ACHUNK_W-1:0] w_aligned;
    logic [IDX_W-1:0]    w_pop_idx;
    logic                w_mem_wr;
    logic [ADDR_W-1:0]   w_mem_wdata;

    assign w_mask    = 8'((9'd1 << i_cfg.align_log2) - 9'd1);
    assign w_offset  = (8'd0 - i_cfg.base_address[7:0]) & w_mask;
    assign w_usable  = (i_cfg.pool_bytes >= {24'd0, w_offset})
                       ? (i_cfg.pool_bytes - {24'd0, w_offset}) : 32'd0;
    assign w_aligned = ({1'b0, i_cfg.chunk_bytes} + {14'd0, w_mask})
                       & ~{14'd0, w_mask};
    assign w_pop_idx = IDX_W'(r_free_count - CNT_W'(1));

    assign w_mem_wr    = i_cmd.push || i_cmd.fill_step;
    assign w_mem_wdata = i_cmd.push ? i_release_address : r_fill_addr;

    always_comb begin
        o_stat.alloc_ok = (r_free_count != '0);
        if (i_release_address == '0) begin
            o_stat.free_code = ST_NULL;
        end else if (r_chunk_total == '0 || i_release_address < i_cfg.base_address
                     || i_release_address > r_last_addr) begin
            o_stat.free_code = ST_RANGE;
        end else if (r_free_count >= r_chunk_total || r_alloc_count == '0) begin
            o_stat.free_code = ST_FULL;
        end else begin
            o_stat.free_code = ST_OK;
        end
        o_stat.fill_more = (r_aligned_chunk != '0)
                           && (r_remain >= {10'd0, r_aligned_chunk})
                           && (r_free_count < CNT_W'(MAX_CHUNKS));
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_wr) begin
            r_stack[r_free_count[IDX_W-1:0]] <= w_mem_wdata;
        end
        if (i_cmd.pop) begin
            r_rd_data <= r_stack[w_pop_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_count    <= '0;
            r_chunk_total   <= '0;
            r_aligned_chunk <= '0;
            r_last_addr     <= '0;
            r_used          <= '0;
            r_alloc_count   <= '0;
            r_popped        <= 1'b0;
            r_code          <= ST_OK;
        end else begin
            if (i_cmd.pop) begin
                r_free_count  <= r_free_count - CNT_W'(1);
                r_used        <= r_used + {10'd0, r_aligned_chunk};
                r_alloc_count <= r_alloc_count + CNT_W'(1);
                r_popped      <= 1'b1;
                r_code        <= ST_OK;
            end
            if (i_cmd.push) begin
                r_free_count  <= r_free_count + CNT_W'(1);
                r_used        <= r_used - {10'd0, r_aligned_chunk};
                r_alloc_count <= r_alloc_count - CNT_W'(1);
                r_popped      <= 1'b0;
                r_code        <= ST_OK;
            end
            if (i_cmd.set_code) begin
                r_popped <= 1'b0;
                r_code   <= i_cmd.code;
            end
            if (i_cmd.clear_init) begin
                r_free_count    <= '0;
                r_chunk_total   <= '0;
                r_aligned_chunk <= w_aligned;
                r_last_addr     <= '0;
                r_used          <= '0;
                r_alloc_count   <= '0;
                r_popped        <= 1'b0;
                r_code          <= ST_OK;
            end
            if (i_cmd.fill_step) begin
                r_free_count <= r_free_count + CNT_W'(1);
                r_last_addr  <= r_fill_addr;
            end
            if (i_cmd.fill_end) begin
                r_chunk_total <= r_free_count;
            end
        end
    end

    // fill walker: subtract-and-count stands in for the chunk count division
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_init) begin
            r_remain    <= w_usable;
            r_fill_addr <= i_cfg.base_address + {24'd0, w_offset};
        end else if (i_cmd.fill_step) begin
            r_remain    <= r_remain - {10'd0, r_aligned_chunk};
            r_fill_addr <= r_fill_addr + {10'd0, r_aligned_chunk};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_addr   <= r_popped ? r_rd_data : '0;
            r_out_status <= r_code;
            r_out_used   <= r_used;
            r_out_alloc  <= r_alloc_count;
        end
    end

    assign o_chunk_address    = r_out_addr;
    assign o_status           = r_out_status;
    assign o_used_bytes       = r_out_used;
    assign o_live_allocations = r_out_alloc;

endmodule

`default_nettype wire

// ===== design/fixed_chunk_pool_allocator.sv =====
// Sequence: allocate, free and unused requests go from idle to the response
//   state, which loads the result once the output is free; clear first adds
//   n chunks (n up to 1024) in the fill state. A request is taken only in idle.
// Clear walks the region one chunk per cycle through a single subtract/compare.
// Reset: synchronous, active low; free list empty and counters zero until the
//   first clear; control and configuration registers return to their reset values.
// ----------------------------------------------------------------------------
// fixed_chunk_pool_allocator
// Fixed-size chunk pool with a LIFO free stack, APB register port and
// stream request/result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_chunk_pool_allocator
    import fcpa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // [31:0] release_address
    input  wire logic [1:0]  i_s_axis_tuser,  // [1:0] req_type
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [79:0]      o_m_axis_tdata,  // [31:0] chunk_address,
                                              // [63:32] used_bytes,
                                              // [74:64] live_allocations
    output logic [2:0]       o_m_axis_tuser,  // [2:0] status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg                r_cfg;
    t_cmd                w_cmd;
    t_stat               w_stat;
    logic [ADDR_W-1:0]   w_chunk_address;
    logic [STAT_W-1:0]   w_status;
    logic [31:0]         w_used;
    logic [CNT_W-1:0]    w_live;
    logic                w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_address <= '0;
            r_cfg.pool_bytes   <= '0;
            r_cfg.chunk_bytes  <= CHUNK_W'(16);
            r_cfg.align_log2   <= ALIGN_W'(3);
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_BASE:  r_cfg.base_address <= pwdata;
                REG_POOL:  r_cfg.pool_bytes   <= pwdata;
                REG_CHUNK: r_cfg.chunk_bytes  <= pwdata[CHUNK_W-1:0];
                REG_ALIGN: r_cfg.align_log2   <= pwdata[ALIGN_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BASE:  prdata = r_cfg.base_address;
            REG_POOL:  prdata = r_cfg.pool_bytes;
            REG_CHUNK: prdata = {11'd0, r_cfg.chunk_bytes};
            REG_ALIGN: prdata = {29'd0, r_cfg.align_log2};
            default:   prdata = '0;
        endcase
    end

    fcpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_req_type  (i_s_axis_tuser),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    fcpa_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_release_address  (i_s_axis_tdata),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .o_chunk_address    (w_chunk_address),
        .o_status           (w_status),
        .o_used_bytes       (w_used),
        .o_live_allocations (w_live)
    );

    assign o_m_axis_tdata = {5'd0, w_live, w_used, w_chunk_address};
    assign o_m_axis_tuser = w_status;

    a_err_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ST_OK) |-> (o_m_axis_tdata[31:0] == '0))
        else $error("error result carries a chunk address");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[74:64] <= CNT_W'(MAX_CHUNKS)))
        else $error("live allocation count beyond pool capacity");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result raised without a request in progress");

endmodule

`default_nettype wire

// ===== tb/tb_fixed_chunk_pool_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_chunk_pool_allocator
// Drives allocate, free, clear and unused requests into the pool allocator.
// A cycle-free predictor mirrors the free stack and the counters. Every result
// transaction is checked field by field against the oldest prediction. Pool
// geometry is reprogrammed over APB between phases, under varied back-pressure.
// ----------------------------------------------------------------------------

module tb_fixed_chunk_pool_allocator;
    import fcpa_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 10000;

    typedef struct packed {
        logic [31:0] chunk_address;
        logic [2:0]  status;
        logic [31:0] used_bytes;
        logic [10:0] live_allocations;
    } t_pool_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // [31:0] release_address
    logic [1:0]  i_s_axis_tuser;   // [1:0] req_type
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [79:0] o_m_axis_tdata;   // [31:0] chunk_address, [63:32] used_bytes,
                                   // [74:64] live_allocations
    logic [2:0]  o_m_axis_tuser;   // [2:0] status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fixed_chunk_pool_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // pool model
    logic [31:0] cfg_base  = 32'd0;
    logic [31:0] cfg_pool  = 32'd0;
    logic [20:0] cfg_chunk = 21'd16;
    logic [2:0]  cfg_align = 3'd3;
    logic [31:0] free_addrs [MAX_CHUNKS];
    int unsigned free_depth  = 0;
    int unsigned chunk_count = 0;
    int unsigned live_count  = 0;
    logic [21:0] chunk_step   = '0;
    logic [31:0] last_chunk   = '0;
    logic [31:0] bytes_in_use = '0;

    t_pool_result pending_results[$];
    logic [31:0]  live_chunks[$];
    int mismatch_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_len = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic pool_predict(input logic [1:0] req, input logic [31:0] addr,
                                output t_pool_result res);
        logic [31:0] align_v;
        logic [31:0] offset_v;
        logic [31:0] usable_v;
        logic [31:0] step_v;
        logic [31:0] n_v;
        logic [63:0] walk_v;
        int i;
        res = '0;
        res.status = ST_OK;
        case (req)
            REQ_ALLOC: begin
                if (free_depth == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    free_depth--;
                    res.chunk_address = free_addrs[free_depth];
                    bytes_in_use += {10'd0, chunk_step};
                    live_count++;
                end
            end
            REQ_FREE: begin
                if (addr == 32'd0) begin
                    res.status = ST_NULL;
                end else if (chunk_count == 0 || addr < cfg_base || addr > last_chunk) begin
                    res.status = ST_RANGE;
                end else if (free_depth >= chunk_count || free_depth >= MAX_CHUNKS
                             || live_count == 0) begin
                    res.status = ST_FULL;
                end else begin
                    free_addrs[free_depth] = addr;
                    free_depth++;
                    bytes_in_use -= {10'd0, chunk_step};
                    live_count--;
                end
            end
            REQ_CLEAR: begin
                align_v  = 32'd1 << cfg_align;
                offset_v = (align_v - (cfg_base & (align_v - 1))) & (align_v - 1);
                usable_v = (cfg_pool >= offset_v) ? cfg_pool - offset_v : 32'd0;
                step_v   = ({11'd0, cfg_chunk} + align_v - 1) & ~(align_v - 1);
                chunk_step = step_v[21:0];
                n_v = (step_v != 0) ? usable_v / step_v : 32'd0;
                if (n_v > MAX_CHUNKS)
                    n_v = MAX_CHUNKS;
                walk_v = {32'd0, cfg_base} + {32'd0, offset_v};
                for (i = 0; i < n_v; i++) begin
                    free_addrs[i] = walk_v[31:0];
                    walk_v += {32'd0, step_v};
                end
                walk_v -= {32'd0, step_v};
                last_chunk   = (n_v != 0) ? walk_v[31:0] : 32'd0;
                free_depth   = n_v;
                chunk_count  = n_v;
                bytes_in_use = '0;
                live_count   = 0;
            end
            default: ;
        endcase
        res.used_bytes       = bytes_in_use;
        res.live_allocations = live_count[10:0];
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    // one request transaction; leaves tvalid high so back-to-back requests need no toggle
    task automatic send_req(input logic [1:0] req, input logic [31:0] addr,
                            output t_pool_result res);
        int gap;
        gap = 0;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= req;
        i_s_axis_tdata  <= addr;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pool_predict(req, addr, res);
        pending_results.push_back(res);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // registers change only once the block has gone quiet
    task automatic program_pool(input logic [31:0] base, input logic [31:0] pool,
                                input logic [31:0] chunk_word, input logic [31:0] align_word);
        drain_results();
        apb_write(REG_BASE, base);
        apb_write(REG_POOL, pool);
        apb_write(REG_CHUNK, chunk_word);
        apb_write(REG_ALIGN, align_word);
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_base  = base;
        cfg_pool  = pool;
        cfg_chunk = chunk_word[20:0];
        cfg_align = align_word[2:0];
    endtask

    task automatic test_before_clear();
        t_pool_result res;
        send_req(REQ_ALLOC, $urandom, res);
        send_req(REQ_FREE, 32'd0, res);
        send_req(REQ_FREE, 32'h8000_0000, res);
        send_req(REQ_UNUSED, 32'hFFFF_FFFF, res);
        send_req(REQ_CLEAR, 32'd0, res);
    endtask

    // three chunks at 0x1008, 0x1018, 0x1028 from an unaligned base
    task automatic test_small_pool();
        t_pool_result res;
        program_pool(32'h0000_1003, 32'd56, 32'd10, 32'd3);
        send_req(REQ_CLEAR, $urandom, res);
        repeat (4) send_req(REQ_ALLOC, $urandom, res);
        send_req(REQ_FREE, 32'd0, res);
        send_req(REQ_FREE, 32'h0000_1002, res);
        send_req(REQ_FREE, 32'h0000_1029, res);
        send_req(REQ_FREE, 32'h0000_1028, res);
        send_req(REQ_FREE, 32'h0000_1028, res);
        send_req(REQ_FREE, 32'h0000_1003, res);
        send_req(REQ_FREE, 32'h0000_1010, res);
        send_req(REQ_UNUSED, 32'h5555_AAAA, res);
    endtask

    task automatic test_degenerate_pools();
        t_pool_result res;
        // alignment offset larger than the pool
        program_pool(32'h0000_2001, 32'd3, 32'd1, 32'd3);
        send_req(REQ_CLEAR, 32'd0, res);
        send_req(REQ_ALLOC, 32'd0, res);
        // zero chunk size
        program_pool(32'h0000_0100, 32'h0000_1000, 32'd0, 32'd0);
        send_req(REQ_CLEAR, 32'd0, res);
        send_req(REQ_FREE, 32'h0000_0100, res);
        // region wraps past the top of the address space
        program_pool(32'hFFFF_FFF0, 32'h0000_0100, 32'h20, 32'd4);
        send_req(REQ_CLEAR, 32'd0, res);
        send_req(REQ_ALLOC, 32'd0, res);
        send_req(REQ_FREE, res.chunk_address, res);
        // largest chunk, largest pool, saturated count; junk above the field widths
        program_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(REQ_CLEAR, 32'd0, res);
        send_req(REQ_ALLOC, 32'd0, res);
        send_req(REQ_FREE, res.chunk_address, res);
    endtask

    task automatic test_output_stall();
        t_pool_result res;
        logic [31:0] held[$];
        int k;
        program_pool(32'h4000_0000, 32'd1024, 32'd64, 32'd6);
        send_req(REQ_CLEAR, $urandom, res);
        stall_len = 400;
        for (k = 0; k < 24; k++) begin
            send_req(REQ_ALLOC, $urandom, res);
            if (res.status == ST_OK)
                held.push_back(res.chunk_address);
        end
        while (held.size() != 0)
            send_req(REQ_FREE, held.pop_back(), res);
    endtask

    task automatic test_random_traffic(input int n_items);
        t_pool_result res;
        logic [31:0] base;
        logic [31:0] pool;
        logic [20:0] chunk;
        logic [31:0] addr;
        logic [31:0] span;
        logic [1:0]  req;
        int sel;
        int pick;
        int idx;
        int k;
        sel   = $urandom_range(9);
        base  = (sel == 0) ? (32'hFFFF_FF00 | $urandom_range(255)) : $urandom;
        chunk = 21'((sel == 1) ? 32'd0 : (sel == 2) ? $urandom : $urandom_range(1, 300));
        pool  = (sel <= 3) ? $urandom
                           : $urandom_range(0, 48) * chunk + $urandom_range(0, 255);
        program_pool(base, pool, ($urandom & 32'hFFE0_0000) | {11'd0, chunk},
                     ($urandom & 32'hFFFF_FFF8) | $urandom_range(0, 7));
        send_req(REQ_CLEAR, $urandom, res);
        live_chunks.delete();
        for (k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            addr = $urandom;
            if (pick < 45) begin
                req = REQ_ALLOC;
            end else if (pick < 85) begin
                if (live_chunks.size() == 0) begin
                    req = REQ_ALLOC;
                end else begin
                    req  = REQ_FREE;
                    idx  = $urandom_range(live_chunks.size() - 1);
                    addr = live_chunks[idx];
                    live_chunks.delete(idx);
                end
            end else if (pick < 92) begin
                // in or just around the chunk span: repeats, mid-chunk, edges
                req  = REQ_FREE;
                span = (last_chunk >= cfg_base) ? last_chunk - cfg_base : 32'd0;
                if ($urandom_range(1) != 0)
                    addr = cfg_base + $urandom_range(0, span);
                else
                    addr = ($urandom_range(1) != 0) ? cfg_base - $urandom_range(0, 2)
                                                    : last_chunk + $urandom_range(0, 2);
            end else if (pick < 95) begin
                req = REQ_FREE;
                if ($urandom_range(1) != 0)
                    addr = 32'd0;
            end else if (pick < 98) begin
                req = REQ_UNUSED;
            end else begin
                req = REQ_CLEAR;
            end
            send_req(req, addr, res);
            if (req == REQ_ALLOC && res.status == ST_OK)
                live_chunks.push_back(res.chunk_address);
            if (req == REQ_CLEAR)
                live_chunks.delete();
        end
    endtask

    // result side: random tready, or a counted hold-off when requested
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_len > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_len = stall_len - 1;
            end else begin
                i_m_axis_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_pool_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result", o_m_axis_tdata[31:0], 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[31:0] !== want.chunk_address)
                    flag_mismatch("chunk_address", o_m_axis_tdata[31:0], want.chunk_address);
                if (o_m_axis_tuser !== want.status)
                    flag_mismatch("status", {29'd0, o_m_axis_tuser}, {29'd0, want.status});
                if (o_m_axis_tdata[63:32] !== want.used_bytes)
                    flag_mismatch("used_bytes", o_m_axis_tdata[63:32], want.used_bytes);
                if (o_m_axis_tdata[74:64] !== want.live_allocations)
                    flag_mismatch("live_allocations", {21'd0, o_m_axis_tdata[74:64]},
                                  {21'd0, want.live_allocations});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 14;
        rx_idle_pct = 53;
        test_before_clear();
        test_small_pool();
        test_degenerate_pools();
        test_output_stall();
        for (phase = 0; phase < 12; phase++) begin
            if (phase == 4) begin
                tx_idle_pct = 53;
                rx_idle_pct = 14;
            end else if (phase == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            test_random_traffic(140);
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
